### rtl/serial_clock_divider_search_core_assert.svh
// Assertion macros shared by the divider search checker.
// Depends on signals named clk and arst_n in the scope that expands them.
`ifndef SERIAL_CLOCK_DIVIDER_SEARCH_CORE_ASSERT_SVH
`define SERIAL_CLOCK_DIVIDER_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SCDS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scds assertion failed");

// Next-cycle implication, checked out of reset.
`define SCDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scds assertion failed");

`endif

### rtl/scds_pkg.sv
// Shared constants and types for the serial clock divider search.
// No dependencies; used by scds_div and serial_clock_divider_search_core.
package scds_pkg;

	localparam int unsigned MAX_DIVIDE = 254;
	localparam int unsigned MAX_RATE   = 256;
	localparam int unsigned LAST_EVEN  = MAX_DIVIDE & ~32'd1;

	localparam int DATA_W = 32;
	localparam int DVS_W  = DATA_W + 1;
	localparam int DIV_W  = $clog2(LAST_EVEN + 1);
	localparam int RATE_W = $clog2(MAX_RATE + 1);
	localparam int ACC_W  = $clog2((MAX_RATE + 1) * (LAST_EVEN + 2) + 1);
	localparam int CNT_W  = $clog2(DATA_W);

	// Division request toward the shared divider
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

endpackage

### rtl/scds_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on scds_pkg for widths and the request struct.
module scds_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  scds_pkg::div_req_t         req,
	output logic                       done,
	output logic [scds_pkg::DATA_W-1:0] quotient
);

	logic [scds_pkg::DVS_W-1:0]  rem_q;
	logic [scds_pkg::DATA_W-1:0] quo_q;
	logic [scds_pkg::DVS_W-1:0]  dvs_q;
	logic [scds_pkg::CNT_W-1:0]  cnt_q;
	logic                        run_q;
	logic                        done_q;

	logic [scds_pkg::DVS_W:0] shifted;
	logic [scds_pkg::DVS_W:0] diff;
	logic                     ge;

	assign shifted = {rem_q, quo_q[scds_pkg::DATA_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q <= '0;
				quo_q <= req.dividend;
				dvs_q <= req.divisor;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				// remainder stays below the divisor, so it fits DVS_W bits
				rem_q <= ge ? diff[scds_pkg::DVS_W-1:0] : shifted[scds_pkg::DVS_W-1:0];
				quo_q <= {quo_q[scds_pkg::DATA_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == scds_pkg::CNT_W'(scds_pkg::DATA_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/serial_clock_divider_search_core.sv
// Top level of the serial clock divider search: sequencer around one divider.
// Depends on scds_pkg and scds_div.
//
//  channel   direction  handshake               payload
//  command   in         start, busy             target_freq
//  result    out        done (one-cycle strobe) prescale_divide, rate_minus_one,
//                                               achieved_freq, rate_saturated
//  config    in         cfg_valid, cfg_ready    cfg_data (source clock)
//
// One request runs five 32-step divisions on the shared divider plus a prescaler
// search of one compare per even prescaler tried.
// Reset clears the sequencer and loads the source clock register with 96000000.
// busy is high from the cycle after the accepted start up to the done strobe and
// is low again in the strobe cycle, so the next start can transfer at the edge
// that ends it; cfg_ready is the inverse of busy.
// The receiver takes the result in the strobe cycle and cannot stall it.
module serial_clock_divider_search_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic [scds_pkg::DATA_W-1:0] target_freq,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [scds_pkg::DATA_W-1:0] cfg_data,
	// result channel
	output logic                        done,
	output logic [7:0]                  prescale_divide,
	output logic [7:0]                  rate_minus_one,
	output logic [scds_pkg::DATA_W-1:0] achieved_freq,
	output logic                        rate_saturated
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_QUOT,   // quot = source / target
		ST_SEARCH,     // smallest even prescaler with quot / d <= MAX_RATE
		ST_DIV_RATE,   // starting factor = quot / prescaler
		ST_DIV_SRC,    // per-prescaler rate = source / prescaler
		ST_DIV_LIM,    // smallest factor meeting the target
		ST_DIV_ACH     // achieved rate with the final factor
	} state_t;

	localparam logic [scds_pkg::ACC_W-1:0] ACC_STEP = scds_pkg::ACC_W'(2 * (scds_pkg::MAX_RATE + 1));

	state_t                         state_q;
	logic [scds_pkg::DATA_W-1:0]    src_q;
	logic [scds_pkg::DATA_W-1:0]    tgt_q;
	logic [scds_pkg::DATA_W-1:0]    quot_q;
	logic [scds_pkg::DATA_W-1:0]    sd_q;
	logic [scds_pkg::DIV_W-1:0]     div_q;
	logic [scds_pkg::ACC_W-1:0]     acc_q;
	logic [scds_pkg::RATE_W-1:0]    rate_q;
	logic                           dstart_q;
	logic                           done_q;
	logic [7:0]                     presc_q;
	logic [7:0]                     rmo_q;
	logic [scds_pkg::DATA_W-1:0]    ach_q;
	logic                           sat_q;

	scds_pkg::div_req_t             div_req;
	logic                           div_done;
	logic [scds_pkg::DATA_W-1:0]    div_quo;

	logic                           fits;
	logic [scds_pkg::RATE_W-1:0]    rate_clamped;
	logic [scds_pkg::RATE_W-1:0]    rate_limit;
	logic [scds_pkg::RATE_W-1:0]    rate_final;

	// Route operands to the divider by step; it samples them with the start pulse.
	always_comb begin
		div_req.start    = dstart_q;
		div_req.dividend = src_q;
		div_req.divisor  = {1'b0, tgt_q};
		unique case (state_q)
			ST_DIV_QUOT: begin
				div_req.dividend = src_q;
				div_req.divisor  = {1'b0, tgt_q};
			end
			ST_DIV_RATE: begin
				div_req.dividend = quot_q;
				div_req.divisor  = scds_pkg::DVS_W'(div_q);
			end
			ST_DIV_SRC: begin
				div_req.dividend = src_q;
				div_req.divisor  = scds_pkg::DVS_W'(div_q);
			end
			ST_DIV_LIM: begin
				// target + 1 may reach 2^32, hence the extra divisor bit
				div_req.dividend = sd_q;
				div_req.divisor  = {1'b0, tgt_q} + scds_pkg::DVS_W'(1);
			end
			ST_DIV_ACH: begin
				div_req.dividend = sd_q;
				div_req.divisor  = scds_pkg::DVS_W'(rate_q);
			end
			default: begin
				div_req.dividend = src_q;
				div_req.divisor  = {1'b0, tgt_q};
			end
		endcase
	end

	scds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// quot / d <= MAX_RATE is the same as quot < (MAX_RATE + 1) * d
	assign fits = quot_q < scds_pkg::DATA_W'(acc_q);

	// Starting factor: raise zero to one, clamp at MAX_RATE.
	always_comb begin
		if (div_quo == '0)
			rate_clamped = scds_pkg::RATE_W'(1);
		else if (div_quo > scds_pkg::DATA_W'(scds_pkg::MAX_RATE))
			rate_clamped = scds_pkg::RATE_W'(scds_pkg::MAX_RATE);
		else
			rate_clamped = scds_pkg::RATE_W'(div_quo);
	end

	// floor(sd / r) <= target first holds at r = floor(sd / (target + 1)) + 1;
	// the factor only ever grows from its start and stops at MAX_RATE.
	always_comb begin
		if (div_quo >= scds_pkg::DATA_W'(scds_pkg::MAX_RATE - 1))
			rate_limit = scds_pkg::RATE_W'(scds_pkg::MAX_RATE);
		else
			rate_limit = scds_pkg::RATE_W'(div_quo) + scds_pkg::RATE_W'(1);
		rate_final = (rate_limit > rate_q) ? rate_limit : rate_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			src_q    <= scds_pkg::DATA_W'(96000000);
			tgt_q    <= '0;
			quot_q   <= '0;
			sd_q     <= '0;
			div_q    <= '0;
			acc_q    <= '0;
			rate_q   <= '0;
			dstart_q <= 1'b0;
			done_q   <= 1'b0;
			presc_q  <= '0;
			rmo_q    <= '0;
			ach_q    <= '0;
			sat_q    <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			done_q   <= 1'b0;
			if (cfg_valid && cfg_ready)
				src_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						// treat a zero target as one
						tgt_q    <= (target_freq == '0) ? scds_pkg::DATA_W'(1) : target_freq;
						dstart_q <= 1'b1;
						state_q  <= ST_DIV_QUOT;
					end
				end
				ST_DIV_QUOT: begin
					if (div_done) begin
						quot_q  <= div_quo;
						div_q   <= scds_pkg::DIV_W'(2);
						acc_q   <= ACC_STEP;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// stop on a fit, or hold the last even prescaler when none fits
					if (fits || div_q == scds_pkg::DIV_W'(scds_pkg::LAST_EVEN)) begin
						dstart_q <= 1'b1;
						state_q  <= ST_DIV_RATE;
					end else begin
						div_q <= div_q + scds_pkg::DIV_W'(2);
						acc_q <= acc_q + ACC_STEP;
					end
				end
				ST_DIV_RATE: begin
					if (div_done) begin
						rate_q   <= rate_clamped;
						dstart_q <= 1'b1;
						state_q  <= ST_DIV_SRC;
					end
				end
				ST_DIV_SRC: begin
					if (div_done) begin
						sd_q     <= div_quo;
						dstart_q <= 1'b1;
						state_q  <= ST_DIV_LIM;
					end
				end
				ST_DIV_LIM: begin
					if (div_done) begin
						rate_q   <= rate_final;
						dstart_q <= 1'b1;
						state_q  <= ST_DIV_ACH;
					end
				end
				ST_DIV_ACH: begin
					if (div_done) begin
						presc_q <= 8'(div_q);
						rmo_q   <= 8'(rate_q - scds_pkg::RATE_W'(1));
						ach_q   <= div_quo;
						sat_q   <= div_quo > tgt_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign cfg_ready       = ~busy;
	assign done            = done_q;
	assign prescale_divide = presc_q;
	assign rate_minus_one  = rmo_q;
	assign achieved_freq   = ach_q;
	assign rate_saturated  = sat_q;

endmodule

### rtl/scds_checker.sv
// Port-level checks for serial_clock_divider_search_core, bound to the top level.
// Depends on scds_pkg and serial_clock_divider_search_core_assert.svh.
`include "serial_clock_divider_search_core_assert.svh"

module scds_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [7:0]                  prescale_divide,
	input logic [7:0]                  rate_minus_one,
	input logic                        rate_saturated
);

	logic presc_ok;

	assign presc_ok = !prescale_divide[0] && prescale_divide >= 8'd2
		&& prescale_divide <= 8'(scds_pkg::LAST_EVEN);

	// an accepted command keeps the block busy in the next cycle
	`SCDS_ASSERT_NEXT(a_start_busy, start && !busy, busy)

	// done falls again after each strobe
	`SCDS_ASSERT_NEXT(a_done_pulse, done, !done)

	// the prescaler is even and inside its range
	`SCDS_ASSERT_NOW(a_presc_range, done, presc_ok)

	// the target can only be missed with the factor at its ceiling
	`SCDS_ASSERT_NOW(a_sat_full, done && rate_saturated, rate_minus_one == 8'(scds_pkg::MAX_RATE - 1))

endmodule

bind serial_clock_divider_search_core scds_checker u_scds_checker (.*);
